// ===== rtl/dde_pkg.sv =====
// dde_pkg: shared types and constants of the debounced digit editor
// request and result payload structs, key group struct, field widths
// no dependencies
package dde_pkg;

  localparam int unsigned DigitW     = 4;
  localparam int unsigned CursorW    = 2;
  localparam int unsigned TickFieldW = 32;
  localparam int unsigned LockoutW   = 16;
  localparam int unsigned NumKeys    = 5;
  localparam int unsigned OutDigits  = 4;

  localparam logic [LockoutW-1:0] LockoutReset = 16'd60;
  localparam logic [DigitW-1:0]   DigitMax     = 4'd9;
  localparam logic [DigitW-1:0]   DigitZero    = 4'd0;

  typedef logic [DigitW-1:0] digit_t;

  // input request: one poll of the joystick plus the tick count
  typedef struct packed {
    logic                  key_up;
    logic                  key_down;
    logic                  key_left;
    logic                  key_right;
    logic                  key_center;
    logic [TickFieldW-1:0] now_tick;
  } dde_in_t;

  // result: shown digits and cursor
  typedef struct packed {
    digit_t               digit_zero;
    digit_t               digit_one;
    digit_t               digit_two;
    digit_t               digit_three;
    logic [CursorW-1:0]   cursor;
  } dde_out_t;

  // one bit per button, in evaluation order
  typedef struct packed {
    logic up;
    logic right;
    logic left;
    logic down;
    logic ok;
  } dde_keys_t;

endpackage

// ===== rtl/dde_key_filter.sv =====
// dde_key_filter: rising edge detect and per-button lockout of the five keys
// keeps previous levels and last accepted tick per button
// depends on dde_pkg
module dde_key_filter #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  dde_pkg::dde_keys_t            levels_i,
  input  logic [TICK_BITS-1:0]          now_i,
  input  logic [dde_pkg::LockoutW-1:0]  lockout_i,
  output dde_pkg::dde_keys_t            accept_o
);

  logic [dde_pkg::NumKeys-1:0]                prev_q;
  logic [dde_pkg::NumKeys-1:0][TICK_BITS-1:0] last_q;
  logic [dde_pkg::NumKeys-1:0]                lvl;
  logic [dde_pkg::NumKeys-1:0]                acc;
  logic [dde_pkg::NumKeys-1:0][TICK_BITS-1:0] diff;
  logic [TICK_BITS-1:0]                       lock_ext;

  assign lvl      = levels_i;
  assign lock_ext = TICK_BITS'(lockout_i);

  always_comb begin
    for (int k = 0; k < dde_pkg::NumKeys; k++) begin
      // wraps modulo 2^TICK_BITS
      diff[k] = now_i - last_q[k];
      acc[k]  = fire_i && lvl[k] && !prev_q[k] && (diff[k] > lock_ext);
    end
  end

  assign accept_o = dde_pkg::dde_keys_t'(acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      last_q <= '0;
    end else if (fire_i) begin
      prev_q <= lvl;
      for (int k = 0; k < dde_pkg::NumKeys; k++) begin
        if (acc[k]) begin
          last_q[k] <= now_i;
        end
      end
    end
  end

endmodule

// ===== rtl/dde_digit_core.sv =====
// dde_digit_core: digit store and cursor, updated by accepted presses
// applies up, right, left, down, ok in that order within one request
// depends on dde_pkg
module dde_digit_core #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    fire_i,
  input  dde_pkg::dde_keys_t                      accept_i,
  output dde_pkg::digit_t [DIGIT_COUNT-1:0]       digits_o,
  output logic [$clog2(DIGIT_COUNT)-1:0]          cursor_o
);

  localparam int unsigned CurW = $clog2(DIGIT_COUNT);
  localparam logic [CurW-1:0] CurLast = CurW'(DIGIT_COUNT - 1);

  dde_pkg::digit_t [DIGIT_COUNT-1:0] digits_q, digits_d;
  logic [CurW-1:0] cursor_q, c1, c2;

  always_comb begin
    // right and left wrap around the digit count
    c1 = cursor_q;
    if (accept_i.right) begin
      c1 = (cursor_q == CurLast) ? '0 : cursor_q + 1'b1;
    end
    c2 = c1;
    if (accept_i.left) begin
      c2 = (c1 == '0) ? CurLast : c1 - 1'b1;
    end
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      digits_d[i] = digits_q[i];
      // up uses the cursor before any move, down the cursor after both moves
      if (accept_i.up && (cursor_q == CurW'(i))) begin
        digits_d[i] = (digits_d[i] >= dde_pkg::DigitMax) ? dde_pkg::DigitZero
                                                         : digits_d[i] + 1'b1;
      end
      if (accept_i.down && (c2 == CurW'(i))) begin
        digits_d[i] = ((digits_d[i] == dde_pkg::DigitZero) ||
                       (digits_d[i] > dde_pkg::DigitMax)) ? dde_pkg::DigitMax
                                                          : digits_d[i] - 1'b1;
      end
      if (accept_i.ok) begin
        digits_d[i] = dde_pkg::DigitZero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digits_q <= '0;
      cursor_q <= '0;
    end else if (fire_i) begin
      digits_q <= digits_d;
      cursor_q <= c2;
    end
  end

  assign digits_o = digits_q;
  assign cursor_o = cursor_q;

endmodule

// ===== rtl/debounced_digit_editor_top.sv =====
// debounced_digit_editor_top: joystick driven four digit editor with key lockout
// input register, key filter, digit core; the digit core state is the result
// depends on dde_pkg, dde_key_filter, dde_digit_core

// Takes one poll request per clock unless the output stalls, and returns one
// result per request. A request is captured in an input register; once the
// output can advance, the key filter and the digit core update their state in
// a single pass, and that registered state is the result shown on the output
// port. While a result waits for out_ready_i one more request is held in the
// input register; throughput is one request per cycle while not stalled, set
// by the single state update per clock. The user must write lockout_ticks via
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce this.
module debounced_digit_editor_top #(
  parameter int unsigned DIGIT_COUNT = 4,
  parameter int unsigned TICK_BITS   = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dde_pkg::LockoutW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  dde_pkg::dde_in_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output dde_pkg::dde_out_t             out_rsp_o
);

  localparam int unsigned CurW = $clog2(DIGIT_COUNT);

  logic [dde_pkg::LockoutW-1:0] lockout_q;
  logic                         in_valid_q, out_valid_q;
  dde_pkg::dde_in_t             in_q;
  logic                         advance, fire;
  dde_pkg::dde_keys_t           levels, accept;
  dde_pkg::digit_t [DIGIT_COUNT-1:0] digits;
  dde_pkg::digit_t [dde_pkg::OutDigits-1:0] shown;
  logic [CurW-1:0]              cursor;

  assign advance    = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lockout_q <= dde_pkg::LockoutReset;
    end else if (cfg_we_i) begin
      lockout_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_req_i;
    end
  end

  always_comb begin
    levels.up    = in_q.key_up;
    levels.right = in_q.key_right;
    levels.left  = in_q.key_left;
    levels.down  = in_q.key_down;
    levels.ok    = in_q.key_center;
  end

  dde_key_filter #(
    .TICK_BITS(TICK_BITS)
  ) u_key_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .levels_i (levels),
    .now_i    (in_q.now_tick[TICK_BITS-1:0]),
    .lockout_i(lockout_q),
    .accept_o (accept)
  );

  dde_digit_core #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_digit_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .accept_i(accept),
    .digits_o(digits),
    .cursor_o(cursor)
  );

  // missing positions read zero, extra positions are not shown
  for (genvar g = 0; g < dde_pkg::OutDigits; g++) begin : g_shown
    if (g < DIGIT_COUNT) begin : g_have
      assign shown[g] = digits[g];
    end else begin : g_none
      assign shown[g] = dde_pkg::DigitZero;
    end
  end

  logic [CurW+dde_pkg::CursorW-1:0] cursor_ext;
  assign cursor_ext = {{dde_pkg::CursorW{1'b0}}, cursor};

  always_comb begin
    out_rsp_o.digit_zero  = shown[0];
    out_rsp_o.digit_one   = shown[1];
    out_rsp_o.digit_two   = shown[2];
    out_rsp_o.digit_three = shown[3];
    out_rsp_o.cursor      = cursor_ext[dde_pkg::CursorW-1:0];
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/dde_checker.sv =====
// dde_checker: port level checks of debounced_digit_editor_top
// bound to the top level below; depends on dde_pkg
module dde_checker #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [dde_pkg::LockoutW-1:0]  cfg_wdata_i,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input dde_pkg::dde_in_t              in_req_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input dde_pkg::dde_out_t             out_rsp_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // input side only blocks when a result is stuck
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without output backpressure");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.digit_zero <= dde_pkg::DigitMax) &&
                    (out_rsp_o.digit_one <= dde_pkg::DigitMax) &&
                    (out_rsp_o.digit_two <= dde_pkg::DigitMax) &&
                    (out_rsp_o.digit_three <= dde_pkg::DigitMax))
    else $error("digit out of range");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (DIGIT_COUNT >= dde_pkg::OutDigits) ||
                    (32'(out_rsp_o.cursor) < DIGIT_COUNT))
    else $error("cursor out of range");

endmodule

bind debounced_digit_editor_top dde_checker #(
  .DIGIT_COUNT(DIGIT_COUNT)
) u_dde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cfg_we_i   (cfg_we_i),
  .cfg_wdata_i(cfg_wdata_i),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_req_i   (in_req_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_rsp_o  (out_rsp_o)
);
